/* design/apptu_pkg.sv */
// Package for the adaptive poll period tuner unit.
// Item types, controller/datapath command and status structs, register codes and reset values.
// No dependencies.
package apptu_pkg;

  localparam int DEF_PERIOD_SLOTS = 32;

  localparam int PER_W  = 5;
  localparam int SCAN_W = PER_W + 1;
  localparam int MSC_W  = 16;
  localparam int DIV_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLE_CYCLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_DIVISOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPROVE_DIVISOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOMMEND_DIVISOR = 3'd6;

  localparam logic [PER_W-1:0] RST_INITIAL_PERIOD    = 5'd10;
  localparam logic [PER_W-1:0] RST_MIN_PERIOD        = 5'd1;
  localparam logic [PER_W-1:0] RST_MAX_PERIOD        = 5'd20;
  localparam logic [MSC_W-1:0] RST_MIN_SAMPLE_CYCLES = 16'd200;
  localparam logic [DIV_W-1:0] RST_DEGRADE_DIVISOR   = 10'd50;
  localparam logic [DIV_W-1:0] RST_IMPROVE_DIVISOR   = 10'd200;
  localparam logic [DIV_W-1:0] RST_RECOMMEND_DIVISOR = 10'd100;

  typedef struct packed {
    logic [11:0] cycle_count;
    logic [13:0] comm_failures;
    logic [11:0] deadline_misses;
  } in_item_t;

  typedef struct packed {
    logic [PER_W-1:0] read_period;
    logic [PER_W-1:0] recommended_period;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_DEG,
    MUL_IMP,
    MUL_REC,
    MUL_I_BC,
    MUL_BI_C
  } mul_sel_e;

  typedef struct packed {
    logic              load_in;
    logic              rd_en;
    logic              rd_cur;
    logic [SCAN_W-1:0] rd_p;
    logic [SCAN_W-1:0] scan_p;
    logic              acc_wr;
    mul_sel_e          mul_sel;
    logic              latch_deg;
    logic              latch_stb;
    logic              latch_ci;
    logic              save_prod;
    logic              p2_init;
    logic              p2_cmp;
    logic              best_from_p;
    logic              best_from_pick;
    logic              adjust;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

endpackage

/* design/apptu_dp.sv */
// Datapath of the adaptive poll period tuner unit: statistics memory, shared multiplier,
// scan registers, period state and result register.
// Depends on apptu_pkg.
module apptu_dp #(
  parameter int PERIOD_SLOTS = apptu_pkg::DEF_PERIOD_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apptu_pkg::cmd_t               cmd_i,
  output apptu_pkg::sts_t               sts_o,
  input  apptu_pkg::in_item_t           in_item_i,
  input  logic [apptu_pkg::PER_W-1:0]   cfg_min_i,
  input  logic [apptu_pkg::PER_W-1:0]   cfg_max_i,
  input  logic [apptu_pkg::MSC_W-1:0]   cfg_msc_i,
  input  logic [apptu_pkg::DIV_W-1:0]   cfg_deg_i,
  input  logic [apptu_pkg::DIV_W-1:0]   cfg_imp_i,
  input  logic [apptu_pkg::DIV_W-1:0]   cfg_rec_i,
  output apptu_pkg::out_item_t          out_item_o
);

  localparam int SLOT_W = $clog2(PERIOD_SLOTS);
  localparam int EW = (SLOT_W > apptu_pkg::SCAN_W) ? SLOT_W : apptu_pkg::SCAN_W;

  typedef struct packed {
    logic [31:0] cyc;
    logic [31:0] iss;
  } entry_t;

  entry_t                        mem_q [PERIOD_SLOTS];
  logic [PERIOD_SLOTS-1:0]       vld_q;
  entry_t                        rdata_q;
  logic                          rd_vld_q;
  logic [apptu_pkg::SCAN_W-1:0]  rd_p;
  logic [EW-1:0]                 rd_ext, wr_ext;
  logic [SLOT_W-1:0]             rd_idx, wr_idx;
  logic                          cur_ok, wr_en;
  logic [31:0]                   ent_c, ent_i;
  logic [32:0]                   csum, isum;
  entry_t                        wr_ent;

  logic [11:0]                   cyc_q;
  logic [14:0]                   iss_q;
  logic                          deg_q, stb_q;
  logic [31:0]                   c_q, i_q, bi_q, bc_q;
  logic [63:0]                   prod_q, prod_a_q;
  logic [31:0]                   mul_a, mul_b;
  logic                          have_q, take;
  logic [apptu_pkg::PER_W-1:0]   pick_q, best_q, cur_q;
  logic [1:0]                    sw_q;
  apptu_pkg::out_item_t          out_q;

  assign rd_p   = cmd_i.rd_cur ? {1'b0, cur_q} : cmd_i.rd_p;
  assign rd_ext = EW'(rd_p);
  assign wr_ext = EW'(cur_q);
  assign rd_idx = rd_ext[SLOT_W-1:0];
  assign wr_idx = wr_ext[SLOT_W-1:0];
  assign cur_ok = 32'(cur_q) < PERIOD_SLOTS;
  assign wr_en  = cmd_i.acc_wr && cur_ok;

  // entries never written read as zero
  assign ent_c = rd_vld_q ? rdata_q.cyc : '0;
  assign ent_i = rd_vld_q ? rdata_q.iss : '0;

  assign csum = {1'b0, ent_c} + 33'(cyc_q);
  assign isum = {1'b0, ent_i} + 33'(iss_q);
  assign wr_ent.cyc = csum[32] ? '1 : csum[31:0];
  assign wr_ent.iss = isum[32] ? '1 : isum[31:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_idx];
      end
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      apptu_pkg::MUL_DEG: begin
        mul_a = 32'(iss_q);
        mul_b = 32'(cfg_deg_i);
      end
      apptu_pkg::MUL_IMP: begin
        mul_a = 32'(iss_q);
        mul_b = 32'(cfg_imp_i);
      end
      apptu_pkg::MUL_REC: begin
        mul_a = ent_i;
        mul_b = 32'(cfg_rec_i);
      end
      apptu_pkg::MUL_I_BC: begin
        mul_a = ent_i;
        mul_b = bc_q;
      end
      apptu_pkg::MUL_BI_C: begin
        mul_a = bi_q;
        mul_b = c_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sts_o.hit = (c_q != '0) && (c_q >= 32'(cfg_msc_i)) && (prod_q <= 64'(c_q));
  assign take = (c_q != '0) && (!have_q || (prod_a_q < prod_q));

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_in) begin
      cyc_q <= in_item_i.cycle_count;
      iss_q <= 15'(in_item_i.comm_failures) + 15'(in_item_i.deadline_misses);
    end
    if (cmd_i.latch_deg) begin
      deg_q <= (cyc_q != '0) && (prod_q > 64'(cyc_q));
    end
    if (cmd_i.latch_stb) begin
      stb_q <= (cyc_q == '0) || (prod_q < 64'(cyc_q));
    end
    if (cmd_i.latch_ci) begin
      c_q <= ent_c;
      i_q <= ent_i;
    end
    if (cmd_i.save_prod) begin
      prod_a_q <= prod_q;
    end
    if (cmd_i.p2_init) begin
      bi_q <= '0;
      bc_q <= 32'd1;
    end else if (cmd_i.p2_cmp && take) begin
      bi_q <= i_q;
      bc_q <= c_q;
    end
    if (cmd_i.out_load) begin
      out_q.read_period        <= cur_q;
      out_q.recommended_period <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pick_q <= apptu_pkg::RST_INITIAL_PERIOD;
      best_q <= apptu_pkg::RST_INITIAL_PERIOD;
      cur_q  <= apptu_pkg::RST_INITIAL_PERIOD;
      sw_q   <= '0;
    end else begin
      if (cmd_i.p2_init) begin
        have_q <= 1'b0;
        pick_q <= cur_q;
      end else if (cmd_i.p2_cmp && take) begin
        have_q <= 1'b1;
        pick_q <= cmd_i.scan_p[apptu_pkg::PER_W-1:0];
      end
      if (cmd_i.best_from_p) begin
        best_q <= cmd_i.scan_p[apptu_pkg::PER_W-1:0];
      end else if (cmd_i.best_from_pick) begin
        best_q <= pick_q;
      end
      if (cmd_i.adjust) begin
        if (deg_q && (cur_q < cfg_max_i)) begin
          cur_q <= cur_q + 5'd1;
          sw_q  <= '0;
        end else if (stb_q && (cur_q > cfg_min_i)) begin
          if (sw_q != '0) begin
            cur_q <= cur_q - 5'd1;
            sw_q  <= '0;
          end else begin
            sw_q <= sw_q + 2'd1;
          end
        end else begin
          sw_q <= '0;
        end
      end
    end
  end

  assign out_item_o = out_q;

endmodule

/* design/apptu_ctrl.sv */
// Controller of the adaptive poll period tuner unit: sequences accumulation, window tests
// and the two recommendation scans, and owns the item handshakes.
// Depends on apptu_pkg.
module apptu_ctrl #(
  parameter int PERIOD_SLOTS = apptu_pkg::DEF_PERIOD_SLOTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [apptu_pkg::PER_W-1:0] cfg_min_i,
  input  logic [apptu_pkg::PER_W-1:0] cfg_max_i,
  input  apptu_pkg::sts_t             sts_i,
  output apptu_pkg::cmd_t             cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_WIN_D,
    S_WIN_I,
    S_P1_MUL,
    S_P1_CMP,
    S_P2_INIT,
    S_P2_MA,
    S_P2_MB,
    S_P2_CMP,
    S_P2_END,
    S_FIN,
    S_OUT
  } state_e;

  state_e                       state_q, state_d;
  logic [apptu_pkg::SCAN_W-1:0] p_q, p_d;
  logic                         out_valid_q, out_valid_d;

  function automatic logic in_rng(input logic [apptu_pkg::SCAN_W-1:0] p,
                                  input logic [apptu_pkg::PER_W-1:0] hi);
    in_rng = (p <= {1'b0, hi}) && (32'(p) < PERIOD_SLOTS);
  endfunction

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_sel = apptu_pkg::MUL_DEG;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_cur  = 1'b1;
          state_d       = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_wr  = 1'b1;
        cmd_o.mul_sel = apptu_pkg::MUL_DEG;
        state_d       = S_WIN_D;
      end
      S_WIN_D: begin
        cmd_o.latch_deg = 1'b1;
        cmd_o.mul_sel   = apptu_pkg::MUL_IMP;
        state_d         = S_WIN_I;
      end
      S_WIN_I: begin
        cmd_o.latch_stb = 1'b1;
        p_d = {1'b0, cfg_min_i};
        if (in_rng(p_d, cfg_max_i)) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_P1_MUL;
        end else begin
          state_d = S_P2_INIT;
        end
      end
      S_P1_MUL: begin
        cmd_o.latch_ci = 1'b1;
        cmd_o.mul_sel  = apptu_pkg::MUL_REC;
        state_d        = S_P1_CMP;
      end
      S_P1_CMP: begin
        if (sts_i.hit) begin
          cmd_o.best_from_p = 1'b1;
          state_d           = S_FIN;
        end else begin
          p_d = p_q + 6'd1;
          if (in_rng(p_d, cfg_max_i)) begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_P1_MUL;
          end else begin
            state_d = S_P2_INIT;
          end
        end
      end
      S_P2_INIT: begin
        cmd_o.p2_init = 1'b1;
        p_d = {1'b0, cfg_min_i};
        if (in_rng(p_d, cfg_max_i)) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_P2_MA;
        end else begin
          state_d = S_P2_END;
        end
      end
      S_P2_MA: begin
        cmd_o.latch_ci = 1'b1;
        cmd_o.mul_sel  = apptu_pkg::MUL_I_BC;
        state_d        = S_P2_MB;
      end
      S_P2_MB: begin
        cmd_o.save_prod = 1'b1;
        cmd_o.mul_sel   = apptu_pkg::MUL_BI_C;
        state_d         = S_P2_CMP;
      end
      S_P2_CMP: begin
        cmd_o.p2_cmp = 1'b1;
        p_d = p_q + 6'd1;
        if (in_rng(p_d, cfg_max_i)) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_P2_MA;
        end else begin
          state_d = S_P2_END;
        end
      end
      S_P2_END: begin
        cmd_o.best_from_pick = 1'b1;
        state_d              = S_FIN;
      end
      S_FIN: begin
        cmd_o.adjust = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.rd_p   = p_d;
    cmd_o.scan_p = p_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/adaptive_poll_period_tuner_unit.sv */
// Adaptive poll period tuner unit, top level: configuration registers, controller and datapath.
// Each item is one closed window; the block answers with the period to apply and the
// period recommended from per-period statistics. One item is in work at a time. An item goes
// through accumulation and window tests, a first scan over the slots between min_period and
// max_period that stops at the first qualifying slot, a second scan over the same slots if
// none qualifies, and the period adjustment; its result is loaded once the previous result
// has been taken.
// Each scanned slot costs one read of the statistics memory and one or two products on the
// single shared 32x32 multiplier. Statistics start at zero after reset through per-slot
// valid bits, so no clearing pass is needed.
module adaptive_poll_period_tuner_unit #(
  parameter int PERIOD_SLOTS = apptu_pkg::DEF_PERIOD_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [apptu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apptu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  apptu_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output apptu_pkg::out_item_t             out_item_o
);

  logic [apptu_pkg::PER_W-1:0] min_q, max_q;
  logic [apptu_pkg::MSC_W-1:0] msc_q;
  logic [apptu_pkg::DIV_W-1:0] deg_q, imp_q, rec_q;
  apptu_pkg::cmd_t             cmd;
  apptu_pkg::sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= apptu_pkg::RST_MIN_PERIOD;
      max_q <= apptu_pkg::RST_MAX_PERIOD;
      msc_q <= apptu_pkg::RST_MIN_SAMPLE_CYCLES;
      deg_q <= apptu_pkg::RST_DEGRADE_DIVISOR;
      imp_q <= apptu_pkg::RST_IMPROVE_DIVISOR;
      rec_q <= apptu_pkg::RST_RECOMMEND_DIVISOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        // initial period only matters at reset, where its reset value is loaded
        apptu_pkg::CFG_INITIAL_PERIOD: ;
        apptu_pkg::CFG_MIN_PERIOD: min_q <= cfg_wdata_i[apptu_pkg::PER_W-1:0];
        apptu_pkg::CFG_MAX_PERIOD: max_q <= cfg_wdata_i[apptu_pkg::PER_W-1:0];
        apptu_pkg::CFG_MIN_SAMPLE_CYCLES: msc_q <= cfg_wdata_i[apptu_pkg::MSC_W-1:0];
        apptu_pkg::CFG_DEGRADE_DIVISOR: deg_q <= cfg_wdata_i[apptu_pkg::DIV_W-1:0];
        apptu_pkg::CFG_IMPROVE_DIVISOR: imp_q <= cfg_wdata_i[apptu_pkg::DIV_W-1:0];
        apptu_pkg::CFG_RECOMMEND_DIVISOR: rec_q <= cfg_wdata_i[apptu_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  apptu_ctrl #(
    .PERIOD_SLOTS(PERIOD_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_min_i  (min_q),
    .cfg_max_i  (max_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  apptu_dp #(
    .PERIOD_SLOTS(PERIOD_SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_item_i (in_item_i),
    .cfg_min_i (min_q),
    .cfg_max_i (max_q),
    .cfg_msc_i (msc_q),
    .cfg_deg_i (deg_q),
    .cfg_imp_i (imp_q),
    .cfg_rec_i (rec_q),
    .out_item_o(out_item_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an item");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without an item in work");

  a_dp_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !cmd.adjust && !cmd.rd_en && !in_ready_o)
    else $error("result load overlaps other datapath work");
`endif

endmodule

/* tb/sv/tb_tuner_sb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the poll period tuner testbench: predicts the periods each window yields
// and compares them with the block's results. Depends on apptu_pkg.
package tb_tuner_sb_pkg;

  localparam int SB_SLOTS = apptu_pkg::DEF_PERIOD_SLOTS;

  class tuner_scoreboard;
    logic [apptu_pkg::PER_W-1:0] init_per;
    logic [apptu_pkg::PER_W-1:0] lo_per;
    logic [apptu_pkg::PER_W-1:0] hi_per;
    logic [apptu_pkg::MSC_W-1:0] min_samples;
    logic [apptu_pkg::DIV_W-1:0] deg_div;
    logic [apptu_pkg::DIV_W-1:0] imp_div;
    logic [apptu_pkg::DIV_W-1:0] rec_div;

    logic [apptu_pkg::PER_W-1:0] cur_per;
    logic [apptu_pkg::PER_W-1:0] best_per;
    logic [1:0]                  calm_windows;
    logic [31:0]                 slot_cycles[SB_SLOTS];
    logic [31:0]                 slot_issues[SB_SLOTS];

    apptu_pkg::out_item_t pending_periods[$];
    int n_windows;
    int n_checked;
    int n_errors;
    int n_raised;
    int n_lowered;

    function new();
      init_per = apptu_pkg::RST_INITIAL_PERIOD;
      lo_per = apptu_pkg::RST_MIN_PERIOD;
      hi_per = apptu_pkg::RST_MAX_PERIOD;
      min_samples = apptu_pkg::RST_MIN_SAMPLE_CYCLES;
      deg_div = apptu_pkg::RST_DEGRADE_DIVISOR;
      imp_div = apptu_pkg::RST_IMPROVE_DIVISOR;
      rec_div = apptu_pkg::RST_RECOMMEND_DIVISOR;
      cur_per = init_per;
      best_per = init_per;
      calm_windows = '0;
      foreach (slot_cycles[s]) begin
        slot_cycles[s] = '0;
        slot_issues[s] = '0;
      end
      n_windows = 0;
      n_checked = 0;
      n_errors = 0;
      n_raised = 0;
      n_lowered = 0;
    endfunction

    function void write_reg(logic [apptu_pkg::CFG_IDX_W-1:0] idx,
                            logic [apptu_pkg::CFG_DATA_W-1:0] val);
      unique case (idx)
        apptu_pkg::CFG_INITIAL_PERIOD:    init_per = val[apptu_pkg::PER_W-1:0];
        apptu_pkg::CFG_MIN_PERIOD:        lo_per = val[apptu_pkg::PER_W-1:0];
        apptu_pkg::CFG_MAX_PERIOD:        hi_per = val[apptu_pkg::PER_W-1:0];
        apptu_pkg::CFG_MIN_SAMPLE_CYCLES: min_samples = val[apptu_pkg::MSC_W-1:0];
        apptu_pkg::CFG_DEGRADE_DIVISOR:   deg_div = val[apptu_pkg::DIV_W-1:0];
        apptu_pkg::CFG_IMPROVE_DIVISOR:   imp_div = val[apptu_pkg::DIV_W-1:0];
        apptu_pkg::CFG_RECOMMEND_DIVISOR: rec_div = val[apptu_pkg::DIV_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // first pass: lowest qualifying slot; second pass: lowest ratio, lowest period on ties
    function logic [apptu_pkg::PER_W-1:0] pick_recommended();
      logic [63:0] c;
      logic [63:0] i;
      logic [63:0] bc;
      logic [63:0] bi;
      logic [apptu_pkg::PER_W-1:0] pick;
      bit have;
      int p;
      int lo;
      int hi;
      pick = cur_per;
      have = 1'b0;
      bi = '0;
      bc = 64'd1;
      lo = int'(lo_per);
      hi = int'(hi_per);
      for (p = lo; p <= hi && p < SB_SLOTS; p++) begin
        c = 64'(slot_cycles[p]);
        i = 64'(slot_issues[p]);
        if (c != 0 && c >= 64'(min_samples) && i * 64'(rec_div) <= c)
          return p[apptu_pkg::PER_W-1:0];
      end
      for (p = lo; p <= hi && p < SB_SLOTS; p++) begin
        c = 64'(slot_cycles[p]);
        i = 64'(slot_issues[p]);
        if (c != 0 && (!have || i * bc < bi * c)) begin
          have = 1'b1;
          bi = i;
          bc = c;
          pick = p[apptu_pkg::PER_W-1:0];
        end
      end
      return pick;
    endfunction

    function void note_window(apptu_pkg::in_item_t w);
      logic [63:0] cyc;
      logic [63:0] iss;
      bit degrade;
      bit steady;
      cyc = 64'(w.cycle_count);
      iss = 64'(w.comm_failures) + 64'(w.deadline_misses);
      if (int'(cur_per) < SB_SLOTS) begin
        slot_cycles[cur_per] = sat_add(slot_cycles[cur_per], cyc[31:0]);
        slot_issues[cur_per] = sat_add(slot_issues[cur_per], iss[31:0]);
      end
      best_per = pick_recommended();
      // empty window never degrades and always counts as steady
      if (cyc == 0) begin
        degrade = 1'b0;
        steady = 1'b1;
      end else begin
        degrade = iss * 64'(deg_div) > cyc;
        steady = iss * 64'(imp_div) < cyc;
      end
      if (degrade && cur_per < hi_per) begin
        cur_per = cur_per + 1'b1;
        calm_windows = '0;
        n_raised++;
      end else if (steady && cur_per > lo_per) begin
        calm_windows = calm_windows + 1'b1;
        if (calm_windows >= 2) begin
          cur_per = cur_per - 1'b1;
          calm_windows = '0;
          n_lowered++;
        end
      end else begin
        calm_windows = '0;
      end
      pending_periods.push_back('{read_period: cur_per, recommended_period: best_per});
      n_windows++;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_result(apptu_pkg::out_item_t r);
      apptu_pkg::out_item_t want;
      if (pending_periods.size() == 0) begin
        report_mismatch("result with no window pending", 32'(r.read_period), 32'd0);
        return;
      end
      want = pending_periods.pop_front();
      n_checked++;
      if (r.read_period !== want.read_period)
        report_mismatch("read_period", 32'(r.read_period), 32'(want.read_period));
      if (r.recommended_period !== want.recommended_period)
        report_mismatch("recommended_period", 32'(r.recommended_period),
                        32'(want.recommended_period));
    endtask

    task finish_check();
      if (pending_periods.size() != 0)
        report_mismatch("results never delivered", 32'(pending_periods.size()), 32'd0);
    endtask
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the testbench for adaptive_poll_period_tuner_unit: clock, reset, register and item
// drivers, result monitor and watchdog. Depends on apptu_pkg and tb_tuner_sb_pkg.
module tb_top;

  localparam int GAP_PCT = 23;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_WINDOWS = 225;
  localparam int DRAIN_CYCLES = 200;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [apptu_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [apptu_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  apptu_pkg::in_item_t              in_item_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  apptu_pkg::out_item_t             out_item_o;

  tb_tuner_sb_pkg::tuner_scoreboard sb;
  bit calm = 1'b0;
  int idle_cycles = 0;
  int n_settings = 0;

  adaptive_poll_period_tuner_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
    out_ready_i <= calm || ($urandom_range(0, 99) >= GAP_PCT);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic apptu_pkg::in_item_t window_of(int unsigned cyc, int unsigned fails,
                                                    int unsigned misses);
    apptu_pkg::in_item_t w;
    w.cycle_count = 12'(cyc);
    w.comm_failures = 14'(fails);
    w.deadline_misses = 12'(misses);
    return w;
  endfunction

  // mostly low-issue windows and windows aimed at the three ratio thresholds, plus empty, heavy and raw windows
  function automatic apptu_pkg::in_item_t random_window();
    int unsigned k;
    int unsigned cyc;
    int unsigned iss;
    int unsigned div;
    int unsigned misses;
    k = $urandom_range(0, 99);
    cyc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
    if (k < 10) return window_of(0, $urandom_range(0, 16383), $urandom_range(0, 4095));
    if (k >= 90)
      return window_of($urandom_range(0, 4095), $urandom_range(0, 16383),
                       $urandom_range(0, 4095));
    if (k < 45) begin
      iss = $urandom_range(0, cyc / 400);
    end else if (k < 78) begin
      case ($urandom_range(0, 2))
        0: div = int'(sb.deg_div);
        1: div = int'(sb.imp_div);
        default: div = int'(sb.rec_div);
      endcase
      iss = (div == 0) ? $urandom_range(0, 2) : cyc / div + $urandom_range(0, 2);
      iss = (iss > 0) ? iss - 1 : 0;
    end else begin
      iss = $urandom_range(cyc / 20, 16383);
    end
    misses = $urandom_range(0, (iss < 4095) ? iss : 4095);
    return window_of(cyc, iss - misses, misses);
  endfunction

  task automatic write_reg(input logic [apptu_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[apptu_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    sb.write_reg(idx, val[apptu_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic load_settings(input int unsigned init, lo, hi, samples, deg, imp, rec);
    write_reg(apptu_pkg::CFG_INITIAL_PERIOD, init);
    write_reg(apptu_pkg::CFG_MIN_PERIOD, lo);
    write_reg(apptu_pkg::CFG_MAX_PERIOD, hi);
    write_reg(apptu_pkg::CFG_MIN_SAMPLE_CYCLES, samples);
    write_reg(apptu_pkg::CFG_DEGRADE_DIVISOR, deg);
    write_reg(apptu_pkg::CFG_IMPROVE_DIVISOR, imp);
    write_reg(apptu_pkg::CFG_RECOMMEND_DIVISOR, rec);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_window(input apptu_pkg::in_item_t w);
    if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 180)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_window(w);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_window(random_window());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_periods.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_settings(int'(apptu_pkg::RST_INITIAL_PERIOD), int'(apptu_pkg::RST_MIN_PERIOD),
                  int'(apptu_pkg::RST_MAX_PERIOD), int'(apptu_pkg::RST_MIN_SAMPLE_CYCLES),
                  int'(apptu_pkg::RST_DEGRADE_DIVISOR), int'(apptu_pkg::RST_IMPROVE_DIVISOR),
                  int'(apptu_pkg::RST_RECOMMEND_DIVISOR));
    // empty windows, ratio boundaries, field extremes and bit patterns
    send_window(window_of(0, 0, 0));
    send_window(window_of(0, 16383, 4095));
    send_window(window_of(4095, 0, 0));
    send_window(window_of(4095, 0, 0));
    send_window(window_of(300, 3, 0));
    send_window(window_of(1, 1, 0));
    send_window(window_of(4095, 16383, 4095));
    send_window(window_of(100, 2, 0));
    send_window(window_of(100, 1, 1));
    send_window(window_of(200, 1, 0));
    send_window(window_of(201, 1, 0));
    send_window(window_of(202, 0, 1));
    send_window(window_of(4095, 81, 0));
    send_window(window_of(4095, 0, 82));
    send_window(window_of(2730, 5461, 2730));
    send_window(window_of(1365, 10922, 1365));
    send_window(window_of(2048, 8192, 2048));
    send_window(window_of(4095, 0, 0));
    send_window(window_of(4095, 0, 0));
    send_window(window_of(0, 1, 0));
    send_window(window_of(1, 0, 0));
    send_random(PHASE_WINDOWS);
    settle();

    load_settings(31, 0, 31, 0, 1023, 1, 1023);
    send_random(PHASE_WINDOWS);
    settle();

    load_settings(1, 5, 5, 65535, 1, 1023, 1);
    send_random(PHASE_WINDOWS);
    settle();

    // inverted bounds and zero divisors
    load_settings(0, 20, 3, 1000, 0, 0, 0);
    send_random(PHASE_WINDOWS);
    settle();

    calm <= 1'b1;
    load_settings(17, 1, 31, 4095, 100, 400, 300);
    send_random(PHASE_WINDOWS);
    settle();
    calm <= 1'b0;

    load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
    send_random(PHASE_WINDOWS);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.finish_check();
    $display("tuner run: %0d windows sent, %0d results checked, %0d register settings",
             sb.n_windows, sb.n_checked, n_settings);
    $display("period raised %0d times and lowered %0d times, %0d mismatches",
             sb.n_raised, sb.n_lowered, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* adaptive_poll_period_tuner_unit.f */
design/apptu_pkg.sv
design/apptu_dp.sv
design/apptu_ctrl.sv
design/adaptive_poll_period_tuner_unit.sv
tb/sv/tb_tuner_sb_pkg.sv
tb/sv/tb_top.sv
